@@ design/dcfa_pkg.sv @@
// ----------------------------------------------------------------------------
// dcfa_pkg: shared definitions for the damped cosine force accumulator
// Default sizes, register indexes, datapath widths and the fixed-point
// helpers used to build the kernel table at elaboration.
// ----------------------------------------------------------------------------
package dcfa_pkg;

  localparam int KERNEL_TABLE_ENTRIES_DEF = 1024;
  localparam int KERNEL_RANGE_DEF         = 16;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 64;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_VISCOSITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PEN   = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] VISC_RESET = 32'h0001_0000;
  localparam logic [DATA_W-1:0] INVP_RESET = 32'h0001_0000;

  // 1/(4*pi) in Q30.
  localparam longint INV_4PI_Q30  = 64'sd85445659;
  localparam longint ONE_Q30      = 64'sd1073741824;
  localparam int     TAYLOR_TERMS = 24;

  // Q30 product, rounded half away from zero.
  function automatic longint mulq(input longint a, input longint b);
    logic neg;
    longint unsigned ma, mb, p, r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? 64'(-a) : 64'(a);
    mb  = (b < 0) ? 64'(-b) : 64'(b);
    p   = ma * mb;
    r   = (p + 64'd536870912) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Signed value over a small positive count, truncated toward zero.
  // Restoring shift-and-subtract on the magnitude.
  function automatic longint div_trunc(input longint a, input int d);
    longint unsigned m, q, r;
    m = (a < 0) ? 64'(-a) : 64'(a);
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], m[i]};
      if (r >= 64'(d)) begin
        r    = r - 64'(d);
        q[i] = 1'b1;
      end
    end
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Greatest common divisor of two positive constants.
  function automatic int gcd(input int a, input int b);
    int x, y;
    x = a;
    y = b;
    while (x != y) begin
      if (x > y) begin
        x = x - y;
      end else begin
        y = y - x;
      end
    end
    return x;
  endfunction

endpackage

@@ design/damped_cosine_force_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// damped_cosine_force_accumulator_unit: wall shear stress accumulator
// Each input beat is one bead: tdata carries force_x and height (Q16.16),
// tlast marks the last bead of a configuration. The bead adds
// force * viscosity * K(height * inverse_penetration) to a saturating
// Q32.32 sum, K being an interpolated damped cosine table. On a beat with
// tlast the sum leaves on the master side as tdata, with tuser set if any
// add saturated, and the sum and flag clear. Other beats give no output.
// The configuration channel writes viscosity (index 0) and
// inverse_penetration (index 1); it is always ready and other indexes are
// ignored. Write it only while the block is idle.
// One bead occupies the block from its accepted beat until it returns to idle,
// and no new bead is taken before then; a bead past the table range skips
// the lookup. All products run in sequence through the one shared multiplier,
// with two table reads for the interpolation. The result waits in an output
// register, so the next bead is taken while the receiver stalls; a second last
// bead then holds in its final step until the register frees. Reset clears the
// sum, the flag, and loads 1.0 into both registers; the table needs no fill
// after reset.
// ----------------------------------------------------------------------------
module damped_cosine_force_accumulator_unit
  import dcfa_pkg::*;
#(
  parameter int KERNEL_TABLE_ENTRIES = KERNEL_TABLE_ENTRIES_DEF,
  parameter int KERNEL_RANGE         = KERNEL_RANGE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Bead input.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // [31:0] force_x, [63:32] height
  input  logic                 s_axis_tlast,   // last_bead
  // Stress output.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // [63:0] wall_stress
  output logic                 m_axis_tuser,   // [0] saturated
  // Register writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  // Lookup position scaling: pos = u16 * E / R, with E/R reduced.
  localparam int G     = gcd(KERNEL_TABLE_ENTRIES, KERNEL_RANGE);
  localparam int D_RED = KERNEL_RANGE / G;
  localparam int E_RED = KERNEL_TABLE_ENTRIES / G;
  localparam int UW    = $clog2(KERNEL_RANGE) + 16;
  localparam int SH    = UW + 7;
  localparam int PW    = $clog2(KERNEL_TABLE_ENTRIES) + 17;
  localparam int AW    = $clog2(KERNEL_TABLE_ENTRIES + 1);
  localparam int RIW   = (D_RED > 1) ? $clog2(D_RED) : 1;
  localparam int IW    = PW - 16;
  localparam logic [MUL_W-1:0] RECIP_M =
    MUL_W'(((64'd1 << SH) + 64'(D_RED) - 64'd1) / 64'(D_RED));

  localparam logic [ACC_W-1:0] SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_U    = 13'b0000000000010,
    S_DIV  = 13'b0000000000100,
    S_REM  = 13'b0000000001000,
    S_POS  = 13'b0000000010000,
    S_IDX  = 13'b0000000100000,
    S_RD0  = 13'b0000001000000,
    S_RD1  = 13'b0000010000000,
    S_INT  = 13'b0000100000000,
    S_VA   = 13'b0001000000000,
    S_LO   = 13'b0010000000000,
    S_HI   = 13'b0100000000000,
    S_ACC  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [DATA_W-1:0]        visc_q, invp_q;
  logic [ACC_W-1:0]         sum_q, sum_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q, out_valid_d;
  logic [ACC_W-1:0]         out_data_q;
  logic                     out_sat_q;
  logic                     out_load;

  logic                     fneg_q, fneg_d;
  logic [DATA_W-1:0]        fmag_q, fmag_d;
  logic [DATA_W-1:0]        hgt_q, hgt_d;
  logic                     last_q, last_d;
  logic [UW-1:0]            u16_q, u16_d;
  logic [UW-1:0]            quo_q, quo_d;
  logic [RIW-1:0]           rem_q, rem_d;
  logic [PW-1:0]            pos_q, pos_d;
  logic signed [DATA_W-1:0] ta_q, ta_d;
  logic                     kzero_q, kzero_d;
  logic signed [DATA_W-1:0] kern_q, kern_d;
  logic [DATA_W-1:0]        ahi_q, ahi_d;
  logic [PROD_W-1:0]        plo_q, plo_d;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0]        prod_q;

  logic [AW-1:0]            rom_addr;
  logic signed [DATA_W-1:0] rom_q;

  logic [PW-1:0]            ft [D_RED];
  logic [IW-1:0]            idx;
  logic [DATA_W-1:0]        kmag;
  logic signed [PROD_W-1:0] ip, iq;

  logic                     huge, neg;
  logic [ACC_W-1:0]         mag, room, acc_sum;
  logic                     acc_ovf;

  // Fractional step of the position for each remainder of u16 / D_RED.
  for (genvar g = 0; g < D_RED; g++) begin : g_ft
    localparam int FT_STEP = (g * E_RED) / D_RED;
    assign ft[g] = PW'(FT_STEP);
  end

  dcfa_mul_unit u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod_q)
  );

  dcfa_kernel_rom #(
    .KERNEL_TABLE_ENTRIES (KERNEL_TABLE_ENTRIES),
    .KERNEL_RANGE         (KERNEL_RANGE),
    .AW                   (AW)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_q)
  );

  assign idx  = pos_q[PW-1:16];
  assign kmag = kern_q[DATA_W-1] ? DATA_W'(-kern_q) : DATA_W'(kern_q);
  assign ip   = $signed(prod_q);
  // Division by 65536 truncating toward zero.
  assign iq   = ip[PROD_W-1] ? ((ip + 64'sd65535) >>> 16) : (ip >>> 16);

  // Saturating add of the finished term; prod_q holds the high partial here.
  always_comb begin
    huge    = |prod_q[63:61];
    mag     = huge ? '0 : ((prod_q << 2) + (plo_q >> 30));
    neg     = fneg_q ^ kern_q[DATA_W-1];
    acc_ovf = ovf_q;
    if (neg) begin
      room = sum_q - SUM_MIN;
      if (huge || (mag > room)) begin
        acc_sum = SUM_MIN;
        acc_ovf = 1'b1;
      end else begin
        acc_sum = sum_q - mag;
      end
    end else begin
      room = SUM_MAX - sum_q;
      if (huge || (mag > room)) begin
        acc_sum = SUM_MAX;
        acc_ovf = 1'b1;
      end else begin
        acc_sum = sum_q + mag;
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    sum_d    = sum_q;
    ovf_d    = ovf_q;
    out_load = 1'b0;
    fneg_d   = fneg_q;
    fmag_d   = fmag_q;
    hgt_d    = hgt_q;
    last_d   = last_q;
    u16_d    = u16_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    ta_d     = ta_q;
    kzero_d  = kzero_q;
    kern_d   = kern_q;
    ahi_d    = ahi_q;
    plo_d    = plo_q;
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          fneg_d  = s_axis_tdata[31];
          fmag_d  = s_axis_tdata[31] ? (~s_axis_tdata[31:0] + 32'd1) : s_axis_tdata[31:0];
          hgt_d   = s_axis_tdata[63] ? '0 : s_axis_tdata[63:32];
          last_d  = s_axis_tlast;
          kzero_d = 1'b0;
          state_d = S_U;
        end
      end
      S_U: begin
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, hgt_q});
        mul_b   = $signed({1'b0, invp_q});
        state_d = S_DIV;
      end
      S_DIV: begin
        if (prod_q[63:32] >= 32'(KERNEL_RANGE)) begin
          kzero_d = 1'b1;
          state_d = S_VA;
        end else begin
          u16_d   = prod_q[UW+15:16];
          mul_en  = 1'b1;
          mul_a   = $signed(MUL_W'(prod_q[UW+15:16]));
          mul_b   = $signed(RECIP_M);
          state_d = S_REM;
        end
      end
      S_REM: begin
        quo_d   = prod_q[SH+UW-1:SH];
        mul_en  = 1'b1;
        mul_a   = $signed(MUL_W'(prod_q[SH+UW-1:SH]));
        mul_b   = $signed(MUL_W'(D_RED));
        state_d = S_POS;
      end
      S_POS: begin
        rem_d   = RIW'(u16_q - prod_q[UW-1:0]);
        mul_en  = 1'b1;
        mul_a   = $signed(MUL_W'(quo_q));
        mul_b   = $signed(MUL_W'(E_RED));
        state_d = S_IDX;
      end
      S_IDX: begin
        pos_d   = prod_q[PW-1:0] + ft[rem_q];
        state_d = S_RD0;
      end
      S_RD0: begin
        rom_addr = AW'(idx);
        if (idx >= IW'(KERNEL_TABLE_ENTRIES)) begin
          kzero_d = 1'b1;
          state_d = S_VA;
        end else begin
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        ta_d     = rom_q;
        rom_addr = AW'(idx) + AW'(1);
        state_d  = S_INT;
      end
      S_INT: begin
        mul_en  = 1'b1;
        mul_a   = {rom_q[DATA_W-1], rom_q} - {ta_q[DATA_W-1], ta_q};
        mul_b   = $signed({17'b0, pos_q[15:0]});
        state_d = S_VA;
      end
      S_VA: begin
        kern_d  = kzero_q ? '0 : (ta_q + iq[DATA_W-1:0]);
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, fmag_q});
        mul_b   = $signed({1'b0, visc_q});
        state_d = S_LO;
      end
      S_LO: begin
        ahi_d   = prod_q[63:32];
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, prod_q[31:0]});
        mul_b   = $signed({1'b0, kmag});
        state_d = S_HI;
      end
      S_HI: begin
        plo_d   = prod_q;
        mul_en  = 1'b1;
        mul_a   = $signed({1'b0, ahi_q});
        mul_b   = $signed({1'b0, kmag});
        state_d = S_ACC;
      end
      S_ACC: begin
        if (!last_q) begin
          sum_d   = acc_sum;
          ovf_d   = acc_ovf;
          state_d = S_IDLE;
        end else if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          sum_d    = '0;
          ovf_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      visc_q      <= VISC_RESET;
      invp_q      <= INVP_RESET;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_VISCOSITY: visc_q <= cfg_data_i;
          CFG_INV_PEN:   invp_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fneg_q  <= fneg_d;
    fmag_q  <= fmag_d;
    hgt_q   <= hgt_d;
    last_q  <= last_d;
    u16_q   <= u16_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    ta_q    <= ta_d;
    kzero_q <= kzero_d;
    kern_q  <= kern_d;
    ahi_q   <= ahi_d;
    plo_q   <= plo_d;
    if (out_load) begin
      out_data_q <= acc_sum;
      out_sat_q  <= acc_ovf;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;
  assign cfg_ready_o   = 1'b1;

endmodule

@@ design/dcfa_mul_unit.sv @@
// ----------------------------------------------------------------------------
// dcfa_mul_unit: shared registered multiplier
// One signed 33 x 33 multiply per enabled cycle; the low 64 product bits are
// held until the next enabled cycle.
// ----------------------------------------------------------------------------
module dcfa_mul_unit
  import dcfa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic [PROD_W-1:0]       prod_o
);

  logic signed [2*MUL_W-1:0] full;
  logic [PROD_W-1:0]         prod_q;

  assign full = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[PROD_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

@@ design/dcfa_kernel_rom.sv @@
// ----------------------------------------------------------------------------
// dcfa_kernel_rom: kernel table exp(-u)cos(u)/(4*pi)
// Entries are signed Q30 samples at spacing RANGE/ENTRIES, computed at
// elaboration by a Taylor series and repeated complex powers. One registered
// read port.
// ----------------------------------------------------------------------------
module dcfa_kernel_rom
  import dcfa_pkg::*;
#(
  parameter int KERNEL_TABLE_ENTRIES = KERNEL_TABLE_ENTRIES_DEF,
  parameter int KERNEL_RANGE         = KERNEL_RANGE_DEF,
  parameter int AW                   = $clog2(KERNEL_TABLE_ENTRIES + 1)
) (
  input  logic                     clk_i,
  input  logic [AW-1:0]            addr_i,
  output logic signed [DATA_W-1:0] data_o
);

  typedef logic signed [DATA_W-1:0] ktab_t [KERNEL_TABLE_ENTRIES+1];

  // Sample spacing in Q30, truncated.
  localparam longint H_Q30 =
    (longint'(KERNEL_RANGE) <<< 30) / longint'(KERNEL_TABLE_ENTRIES);

  function automatic ktab_t build_table();
    ktab_t  t;
    longint h, zr, zi, tr, ti, wr, wi, cr, ci, nr, ni;
    int     n, k;
    h  = H_Q30;
    zr = -h;
    zi = h;
    tr = ONE_Q30;
    ti = 0;
    wr = ONE_Q30;
    wi = 0;
    cr = ONE_Q30;
    ci = 0;
    // w = exp((-1+i)h) from its series.
    for (n = 1; n <= TAYLOR_TERMS; n++) begin
      nr = mulq(tr, zr) - mulq(ti, zi);
      ni = mulq(tr, zi) + mulq(ti, zr);
      tr = div_trunc(nr, n);
      ti = div_trunc(ni, n);
      wr = wr + tr;
      wi = wi + ti;
    end
    for (k = 0; k <= KERNEL_TABLE_ENTRIES; k++) begin
      t[k] = DATA_W'(mulq(cr, INV_4PI_Q30));
      nr   = mulq(cr, wr) - mulq(ci, wi);
      ni   = mulq(cr, wi) + mulq(ci, wr);
      cr   = nr;
      ci   = ni;
    end
    return t;
  endfunction

  localparam ktab_t KTAB = build_table();

  logic signed [DATA_W-1:0] data_q;

  always_ff @(posedge clk_i) begin
    data_q <= KTAB[addr_i];
  end

  assign data_o = data_q;

endmodule

@@ bench/tb_damped_cosine_force_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_damped_cosine_force_accumulator_unit: self-checking bench for the unit
// A driver feeds bead beats from a queue and a monitor predicts each stress
// beat with a bit-exact model of the kernel table, the interpolation and the
// saturating sum, then checks every stress beat against the oldest
// prediction. Phases sweep viscosity and inverse penetration settings and
// the idle and stall patterns of both stream sides.
// ----------------------------------------------------------------------------
module tb_damped_cosine_force_accumulator_unit;
  import dcfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAB_N        = KERNEL_TABLE_ENTRIES_DEF;
  localparam int TAB_RANGE    = KERNEL_RANGE_DEF;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASES       = 8;
  localparam int PHASE_BEADS  = 136;

  // Any index past the two registers must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(255);

  typedef struct {
    logic [31:0] force_x;
    logic [31:0] height;
    logic        last;
  } bead_t;

  typedef struct {
    logic [63:0] stress;
    logic        sat;
  } stress_exp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [63:0]          s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [63:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i = '0;

  damped_cosine_force_accumulator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  bead_t       bead_q[$];
  stress_exp_t stress_q[$];

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic [31:0] cur_invp = INVP_RESET;

  int err_count = 0;
  int beads_taken = 0;
  int stress_checked = 0;
  int sat_results = 0;

  // Predictor state.
  int          kern_tab [0:TAB_N];
  logic [31:0] visc_m = VISC_RESET;
  logic [31:0] inv_pen_m = INVP_RESET;
  logic [63:0] stress_sum_m = '0;
  logic        ovf_m = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Q30 product with rounding half away from zero.
  function automatic longint q30_mul(input longint a, input longint b);
    logic            neg;
    longint unsigned ma, mb, r;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    r   = (ma * mb + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // The step factor exp((-1+i)h) comes from a Taylor series; the entries are
  // the real parts of its successive powers scaled by 1/(4*pi).
  function automatic void build_kernel_table();
    longint step, zr, zi, tr, ti, wr, wi, cr, ci, nr, ni;
    step = (longint'(TAB_RANGE) << 30) / longint'(TAB_N);
    zr = -step;
    zi = step;
    tr = ONE_Q30;
    ti = 0;
    wr = ONE_Q30;
    wi = 0;
    cr = ONE_Q30;
    ci = 0;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      nr = q30_mul(tr, zr) - q30_mul(ti, zi);
      ni = q30_mul(tr, zi) + q30_mul(ti, zr);
      tr = nr / longint'(n);
      ti = ni / longint'(n);
      wr += tr;
      wi += ti;
    end
    for (int k = 0; k <= TAB_N; k++) begin
      kern_tab[k] = int'(q30_mul(cr, INV_4PI_Q30));
      nr = q30_mul(cr, wr) - q30_mul(ci, wi);
      ni = q30_mul(cr, wi) + q30_mul(ci, wr);
      cr = nr;
      ci = ni;
    end
  endfunction

  function automatic longint interp_kernel(input logic [31:0] hgt);
    logic [63:0] u, pos;
    logic [15:0] frac;
    longint      idx, t_lo, t_hi;
    u = 64'(hgt) * 64'(inv_pen_m);
    if (u[63:32] >= 32'(TAB_RANGE)) return 0;
    pos  = (u >> 16) * 64'(TAB_N) / 64'(TAB_RANGE);
    idx  = longint'(pos >> 16);
    frac = pos[15:0];
    if (idx >= TAB_N) return 0;
    t_lo = kern_tab[idx];
    t_hi = kern_tab[idx + 1];
    return t_lo + ((t_hi - t_lo) * longint'(frac)) / 65536;
  endfunction

  // Folds one bead into the modeled sum; returns 1 when it yields a stress beat.
  function automatic logic fold_bead(input logic [31:0] fx, input logic [31:0] hb,
                                     input logic last, output logic [63:0] stress,
                                     output logic sat);
    logic        fneg, kneg, huge;
    logic [31:0] hgt;
    logic [63:0] fmag, kmag, prod, plo, phi, mag, room;
    longint      k;
    fneg = fx[31];
    fmag = fneg ? (64'h1_0000_0000 - 64'(fx)) : 64'(fx);
    hgt  = hb[31] ? 32'h0 : hb;
    k    = interp_kernel(hgt);
    kneg = k < 0;
    kmag = kneg ? -k : k;
    prod = fmag * 64'(visc_m);
    plo  = 64'(prod[31:0]) * kmag;
    phi  = (prod >> 32) * kmag;
    huge = phi >= (64'd1 << 61);
    mag  = huge ? 64'h0 : (phi << 2) + (plo >> 30);
    if (fneg != kneg) begin
      room = stress_sum_m - 64'h8000_0000_0000_0000;
      if (huge || mag > room) begin
        stress_sum_m = 64'h8000_0000_0000_0000;
        ovf_m = 1'b1;
      end else begin
        stress_sum_m = stress_sum_m - mag;
      end
    end else begin
      room = 64'h7FFF_FFFF_FFFF_FFFF - stress_sum_m;
      if (huge || mag > room) begin
        stress_sum_m = 64'h7FFF_FFFF_FFFF_FFFF;
        ovf_m = 1'b1;
      end else begin
        stress_sum_m = stress_sum_m + mag;
      end
    end
    stress = stress_sum_m;
    sat    = ovf_m;
    if (last) begin
      stress_sum_m = '0;
      ovf_m = 1'b0;
    end
    return last;
  endfunction

  // Bead driver.
  always @(posedge clk_i) begin
    logic  next_valid;
    bead_t nb;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid && !s_axis_tready;
      if (!next_valid && bead_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        nb = bead_q.pop_front();
        s_axis_tdata <= {nb.height, nb.force_x};
        s_axis_tlast <= nb.last;
        next_valid = 1'b1;
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Stress receiver.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Monitor: tracks register writes, predicts on bead beats, checks stress beats.
  always @(posedge clk_i) begin
    stress_exp_t want;
    logic [63:0] st;
    logic        sa;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_VISCOSITY) begin
          visc_m = cfg_data_i;
        end else if (cfg_index_i == CFG_INV_PEN) begin
          inv_pen_m = cfg_data_i;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (stress_q.size() == 0) begin
          report_mismatch($sformatf("stress beat %h with nothing expected", m_axis_tdata));
        end else begin
          want = stress_q.pop_front();
          stress_checked++;
          if (want.sat) sat_results++;
          if (m_axis_tdata !== want.stress) begin
            report_mismatch($sformatf("wall_stress %h, expected %h",
                                      m_axis_tdata, want.stress));
          end
          if (m_axis_tuser !== want.sat) begin
            report_mismatch($sformatf("saturated %b, expected %b", m_axis_tuser, want.sat));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beads_taken++;
        if (fold_bead(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast, st, sa)) begin
          stress_q.push_back('{stress: st, sat: sa});
        end
      end
    end
  end

  task automatic push_bead(input logic [31:0] fx, input logic [31:0] hb, input logic last);
    bead_q.push_back('{force_x: fx, height: hb, last: last});
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every bead is taken and every stress beat is back, then lets
  // a bead without tlast finish inside the block.
  task automatic wait_idle();
    while (bead_q.size() != 0 || s_axis_tvalid || stress_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_force();
    logic [31:0] f;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 50) return $urandom;
    if (sel < 70) begin
      f = $urandom_range(0, 32'h00FF_FFFF);
      return $urandom_range(1) ? -f : f;
    end
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFF;
      default: return 32'h0001_0000;
    endcase
  endfunction

  // Heights mostly land inside the table for the current penetration setting.
  function automatic logic [31:0] pick_height();
    logic [63:0] reach, edge_h;
    int unsigned sel;
    reach = (cur_invp == 0) ? 64'h7FFF_FFFF : ((64'd17 << 32) / 64'(cur_invp));
    if (reach > 64'h7FFF_FFFF) reach = 64'h7FFF_FFFF;
    sel = $urandom_range(99);
    if (sel < 45) return $urandom_range(0, reach[31:0]);
    if (sel < 60) return $urandom | 32'h8000_0000;
    if (sel < 75) return $urandom;
    if (sel < 85) return $urandom_range(0, 255);
    if (sel < 92) begin
      // Around the first height that reaches the end of the table.
      if (cur_invp == 0) return 32'h7FFF_FFFF;
      edge_h = ((64'd16 << 32) + 64'(cur_invp) - 1) / 64'(cur_invp);
      if (edge_h > 64'h7FFF_FFF0) return 32'h7FFF_FFFF;
      return $urandom_range(edge_h[31:0] - 2, edge_h[31:0] + 2);
    end
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // One configuration: a run of beads closed by tlast. Long runs push one
  // sign near the wall to drive the sum into saturation.
  task automatic push_run(input int len, input logic biased);
    logic [31:0] fx, hb;
    logic        sgn;
    sgn = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      fx = pick_force();
      hb = pick_height();
      if (biased) begin
        fx = sgn ? (fx | 32'h8000_0000) : (fx & 32'h7FFF_FFFF);
        fx[30] = 1'b1;
        hb = $urandom_range(0, 255);
      end
      push_bead(fx, hb, i == len - 1);
    end
  endtask

  initial begin
    logic [31:0] ph_visc [PHASES];
    logic [31:0] ph_invp [PHASES];
    int          queued, len;
    logic        biased;

    build_kernel_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset settings.
    push_bead(32'h0000_0000, 32'h0000_0000, 1'b1);
    push_bead(32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
    push_bead(32'h8000_0000, 32'h0000_0000, 1'b1);
    push_bead(32'h0001_0000, 32'h8000_0000, 1'b1);   // negative height clamps
    push_bead(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_bead(32'h7FFF_FFFF, 32'h0010_0000, 1'b1);   // exactly at the table end
    push_bead(32'h8000_0000, 32'h000F_FFFF, 1'b1);   // just inside the table
    push_bead(32'h1234_5678, 32'h7FFF_FFFF, 1'b0);   // far bead, no result
    push_bead(32'h0003_0000, 32'h0001_8000, 1'b0);
    push_bead(32'hFFFD_0000, 32'h0004_8000, 1'b1);
    wait_idle();

    // Full-scale viscosity: a short run of largest forces saturates the sum.
    write_reg(CFG_VISCOSITY, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_IDX, 32'h0000_0000);
    for (int i = 0; i < 14; i++) push_bead(32'h7FFF_FFFF, 32'h0000_0000, i == 13);
    wait_idle();

    ph_visc[0] = $urandom;       ph_invp[0] = 32'h0001_0000;
    ph_visc[1] = 32'hFFFF_FFFF;  ph_invp[1] = $urandom_range(32'h4000, 32'h40000);
    ph_visc[2] = 32'h0000_0000;  ph_invp[2] = 32'hFFFF_FFFF;
    ph_visc[3] = 32'h0000_8000;  ph_invp[3] = 32'h0000_0000;
    ph_visc[4] = $urandom;       ph_invp[4] = $urandom_range(32'h100, 32'h80000);
    ph_visc[5] = 32'hFFFF_FFFF;  ph_invp[5] = 32'h0000_4000;
    ph_visc[6] = 32'h0000_0001;  ph_invp[6] = 32'h0010_0000;
    ph_visc[7] = $urandom;       ph_invp[7] = 32'h0002_0000;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(CFG_VISCOSITY, ph_visc[p]);
      write_reg(CFG_INV_PEN, ph_invp[p]);
      cur_invp = ph_invp[p];
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 6; sink_stall_pct = 6; end
      endcase
      queued = 0;
      while (queued < PHASE_BEADS) begin
        biased = $urandom_range(99) < 8;
        len = biased ? $urandom_range(14, 40) : $urandom_range(1, 10);
        push_run(len, biased);
        queued += len;
      end
    end

    wait_idle();
    $display("Run covered %0d bead beats over %0d register settings and four idle patterns.",
             beads_taken, PHASES + 2);
    $display("Checked %0d stress beats, %0d of them saturated.", stress_checked, sat_results);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d stress beats outstanding.", stress_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
